/* design/cst_pkg.sv */
package cst_pkg;

  // Command codes
  localparam logic [3:0] CMD_LOCK    = 4'd0;
  localparam logic [3:0] CMD_UNLOCK  = 4'd1;
  localparam logic [3:0] CMD_PREEMPT = 4'd2;
  localparam logic [3:0] CMD_EVICT   = 4'd3;
  localparam logic [3:0] CMD_PIN     = 4'd4;
  localparam logic [3:0] CMD_UNPIN   = 4'd5;
  localparam logic [3:0] CMD_REFRESH = 4'd6;
  localparam logic [3:0] CMD_HOT     = 4'd7;
  localparam logic [3:0] CMD_QUERY   = 4'd8;

  // Chunk residency states
  localparam logic [2:0] ST_COLD    = 3'd0;
  localparam logic [2:0] ST_HOT     = 3'd1;
  localparam logic [2:0] ST_PREEMPT = 3'd2;
  localparam logic [2:0] ST_COPIED  = 3'd3;
  localparam logic [2:0] ST_LOCKED  = 3'd4;
  localparam logic [2:0] ST_EVICTED = 3'd5;

  // Result status codes
  localparam logic [2:0] RS_OK        = 3'd0;
  localparam logic [2:0] RS_RANGE     = 3'd1;
  localparam logic [2:0] RS_BUSY      = 3'd2;
  localparam logic [2:0] RS_NOTLOCKED = 3'd3;
  localparam logic [2:0] RS_NOTRES    = 3'd4;
  localparam logic [2:0] RS_ABORT     = 3'd5;
  localparam logic [2:0] RS_OVERFLOW  = 3'd6;

  localparam int unsigned PIN_W   = 16;
  localparam int unsigned TOUCH_W = 32;
  // Index arithmetic width: a 16-bit chunk index plus one bit for counts
  localparam int unsigned IDX_EXT_W = 17;

  // One entry of the chunk table
  typedef struct packed {
    logic [2:0]         state;
    logic [PIN_W-1:0]   pin;
    logic [TOUCH_W-1:0] touch;
  } chunk_ent_t;

endpackage

/* design/cst_ram.sv */
module cst_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* design/chunk_state_tracker_core.sv */
// Channel   | Direction | Transfer when          | Ports
// ----------+-----------+------------------------+-----------------------------------------
// command   | in        | start & !busy          | cmd_i chunk_index_i range_last_i ...
// result    | out       | done_o (one cycle)     | status_o freed_count_o chunk_state_out_o ..
// config    | in        | cfg_we_i               | cfg_wdata_i (chunks_in_use)
//
// Single-chunk commands read the table, then modify and write back.
// Rejected or trivial commands answer straight from idle. Evict reads and writes
// each chunk visited, pin/unpin/mark hot each chunk in the range, and a lock failure
// adds a log read, chunk read and restore per logged chunk for rollback; all bound
// by the one table port. After reset a clearing pass writes every table entry, busy high.
// Results cannot be stalled; done_o marks each for exactly one cycle.
module chunk_state_tracker_core
  import cst_pkg::*;
#(
  parameter int unsigned MAX_CHUNKS       = 1024,
  parameter int unsigned LOCK_BATCH_DEPTH = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  logic          cfg_we_i,
  input  logic [10:0]   cfg_wdata_i,
  input  logic [3:0]    cmd_i,
  input  logic [15:0]   chunk_index_i,
  input  logic [15:0]   range_last_i,
  input  logic          batch_end_i,
  input  logic          copy_flag_i,
  input  logic [10:0]   evict_chunks_i,
  input  logic [31:0]   now_seconds_i,
  output logic          done_o,
  output logic [2:0]    status_o,
  output logic [10:0]   freed_count_o,
  output logic [2:0]    chunk_state_out_o,
  output logic [15:0]   pin_count_out_o,
  output logic [31:0]   touch_time_out_o
);

  localparam int unsigned AW    = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
  localparam int unsigned LAW   = (LOCK_BATCH_DEPTH > 1) ? $clog2(LOCK_BATCH_DEPTH) : 1;
  localparam int unsigned LLW   = $clog2(LOCK_BATCH_DEPTH + 1);
  localparam int unsigned LOG_W = AW + 3;
  localparam int unsigned EW    = IDX_EXT_W;
  localparam logic [EW-1:0]  MAX_EXT   = EW'(MAX_CHUNKS);
  localparam logic [AW-1:0]  LAST_ADDR = AW'(MAX_CHUNKS - 1);
  localparam logic [LLW-1:0] LOG_FULL  = LLW'(LOCK_BATCH_DEPTH);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_EXEC, S_EV_RD, S_EV_WR, S_RG_RD, S_RG_WR,
    S_RB_LRD, S_RB_CRD, S_RB_CWR
  } state_e;

  state_e            state_q;
  logic [10:0]       cfg_q;
  logic [3:0]        cmd_q;
  logic [15:0]       idx_q;
  logic              end_q;
  logic              copy_q;
  logic [10:0]       want_q;
  logic [31:0]       now_q;
  logic [AW-1:0]     ptr_q;
  logic [AW-1:0]     hi_q;
  logic [EW-1:0]     ev_i_q;
  logic [10:0]       freed_q;
  logic [LLW-1:0]    len_q;
  logic [LLW-1:0]    k_q;
  logic              bf_q;
  logic [2:0]        fail_q;
  logic [LOG_W-1:0]  rb_ent_q;

  // Table and log memory ports
  logic              mem_we;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  chunk_ent_t        mem_wdata, mem_rdata;
  logic              log_we;
  logic [LAW-1:0]    log_raddr;
  logic [LOG_W-1:0]  log_wdata, log_rdata;

  cst_ram #(.WIDTH($bits(chunk_ent_t)), .DEPTH(MAX_CHUNKS)) u_chunk_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  cst_ram #(.WIDTH(LOG_W), .DEPTH(LOCK_BATCH_DEPTH)) u_log_ram (
    .clk_i   (clk_i),
    .we_i    (log_we),
    .waddr_i (len_q[LAW-1:0]),
    .wdata_i (log_wdata),
    .raddr_i (log_raddr),
    .rdata_o (log_rdata)
  );

  // Valid chunk count and range bounds of the incoming command
  logic [EW-1:0] cnt, idx_ext, last_ext, cnt_m1, hi_ext;
  logic          in_rng, rng_bad;
  assign cnt      = ({6'd0, cfg_q} > MAX_EXT) ? MAX_EXT : {6'd0, cfg_q};
  assign idx_ext  = {1'b0, chunk_index_i};
  assign last_ext = {1'b0, range_last_i};
  assign cnt_m1   = cnt - EW'(1);
  assign hi_ext   = (last_ext < cnt_m1) ? last_ext : cnt_m1;
  assign in_rng   = idx_ext < cnt;
  assign rng_bad  = !in_rng || (range_last_i < chunk_index_i);

  // Decode of the entry just read
  logic lk_ok, ev_ok, pre_ok;
  assign lk_ok  = (mem_rdata.state == ST_COLD) || (mem_rdata.state == ST_HOT) ||
                  (mem_rdata.state == ST_PREEMPT) || (mem_rdata.state == ST_COPIED);
  assign ev_ok  = (mem_rdata.pin == '0) && (mem_rdata.state != ST_LOCKED) &&
                  (mem_rdata.state != ST_EVICTED);
  assign pre_ok = (mem_rdata.pin == '0) && ((mem_rdata.state == ST_HOT) ||
                  (mem_rdata.state == ST_COLD) || (mem_rdata.state == ST_COPIED));

  logic [10:0] freed_n;
  assign freed_n = freed_q + {10'd0, ev_ok};

  assign busy = (state_q != S_IDLE);

  // Memory access control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = ptr_q;
    mem_wdata = mem_rdata;
    mem_raddr = ptr_q;
    log_we    = 1'b0;
    log_wdata = {idx_q[AW-1:0], mem_rdata.state};
    log_raddr = k_q[LAW-1:0];
    unique case (state_q)
      S_CLR: begin
        mem_we    = 1'b1;
        mem_wdata = '0;
      end
      S_IDLE: begin
        mem_raddr = chunk_index_i[AW-1:0];
      end
      S_EXEC: begin
        mem_waddr = idx_q[AW-1:0];
        priority case (cmd_q)
          CMD_LOCK: begin
            if (lk_ok && (len_q < LOG_FULL)) begin
              mem_we          = 1'b1;
              mem_wdata.state = ST_LOCKED;
              mem_wdata.touch = now_q;
              log_we          = 1'b1;
            end
          end
          CMD_UNLOCK: begin
            if (mem_rdata.state == ST_LOCKED) begin
              mem_we          = 1'b1;
              mem_wdata.state = copy_q ? ST_COPIED : ST_HOT;
              mem_wdata.touch = now_q;
            end
          end
          CMD_PREEMPT: begin
            mem_we          = pre_ok;
            mem_wdata.state = ST_PREEMPT;
          end
          CMD_REFRESH: begin
            mem_we          = 1'b1;
            mem_wdata.touch = now_q;
          end
          default: ;
        endcase
      end
      S_EV_RD: begin
        mem_raddr = ev_i_q[AW-1:0] - AW'(1);
      end
      S_EV_WR: begin
        mem_we          = ev_ok;
        mem_wdata.state = ST_EVICTED;
      end
      S_RG_RD: ;
      S_RG_WR: begin
        mem_we = 1'b1;
        priority case (cmd_q)
          CMD_PIN: begin
            if (mem_rdata.pin != '1) mem_wdata.pin = mem_rdata.pin + PIN_W'(1);
          end
          CMD_UNPIN: begin
            if (mem_rdata.pin != '0) mem_wdata.pin = mem_rdata.pin - PIN_W'(1);
          end
          default: begin
            mem_wdata.state = ST_HOT;
            mem_wdata.touch = now_q;
          end
        endcase
      end
      S_RB_LRD: ;
      S_RB_CRD: begin
        mem_raddr = log_rdata[LOG_W-1:3];
      end
      S_RB_CWR: begin
        mem_we          = 1'b1;
        mem_waddr       = rb_ent_q[LOG_W-1:3];
        mem_wdata.state = rb_ent_q[2:0];
      end
      default: ;
    endcase
  end

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      cfg_q <= cfg_wdata_i;
    end
  end

  // Sequencer and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q           <= S_CLR;
      ptr_q             <= '0;
      len_q             <= '0;
      bf_q              <= 1'b0;
      k_q               <= '0;
      done_o            <= 1'b0;
      status_o          <= RS_OK;
      freed_count_o     <= '0;
      chunk_state_out_o <= '0;
      pin_count_out_o   <= '0;
      touch_time_out_o  <= '0;
    end else begin
      done_o            <= 1'b0;
      status_o          <= RS_OK;
      freed_count_o     <= '0;
      chunk_state_out_o <= '0;
      pin_count_out_o   <= '0;
      touch_time_out_o  <= '0;
      unique case (state_q)
        S_CLR: begin
          ptr_q <= ptr_q + AW'(1);
          if (ptr_q == LAST_ADDR) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (start) begin
            cmd_q  <= cmd_i;
            idx_q  <= chunk_index_i;
            end_q  <= batch_end_i;
            copy_q <= copy_flag_i;
            want_q <= evict_chunks_i;
            now_q  <= now_seconds_i;
            if ((cmd_i <= CMD_PREEMPT) && bf_q) begin
              // rest of a failed batch
              done_o   <= 1'b1;
              status_o <= RS_ABORT;
              if (batch_end_i) begin
                bf_q <= 1'b0;
                if (cmd_i == CMD_LOCK) len_q <= '0;
              end
            end else begin
              priority case (cmd_i)
                CMD_LOCK: begin
                  if (in_rng) begin
                    state_q <= S_EXEC;
                  end else begin
                    bf_q <= !batch_end_i;
                    if (len_q != '0) begin
                      fail_q  <= RS_RANGE;
                      k_q     <= '0;
                      state_q <= S_RB_LRD;
                    end else begin
                      done_o   <= 1'b1;
                      status_o <= RS_RANGE;
                    end
                  end
                end
                CMD_UNLOCK, CMD_PREEMPT: begin
                  if (in_rng) begin
                    state_q <= S_EXEC;
                  end else begin
                    bf_q     <= !batch_end_i;
                    done_o   <= 1'b1;
                    status_o <= RS_RANGE;
                  end
                end
                CMD_EVICT: begin
                  ev_i_q  <= cnt;
                  freed_q <= '0;
                  if ((cnt == '0) || (evict_chunks_i == '0)) begin
                    done_o <= 1'b1;
                  end else begin
                    state_q <= S_EV_RD;
                  end
                end
                CMD_PIN, CMD_HOT, CMD_UNPIN: begin
                  ptr_q <= chunk_index_i[AW-1:0];
                  hi_q  <= hi_ext[AW-1:0];
                  if (rng_bad) begin
                    done_o   <= 1'b1;
                    status_o <= (cmd_i == CMD_UNPIN) ? RS_OK : RS_RANGE;
                  end else begin
                    state_q <= S_RG_RD;
                  end
                end
                CMD_REFRESH: begin
                  if (in_rng) state_q <= S_EXEC;
                  else done_o <= 1'b1;
                end
                CMD_QUERY: begin
                  if (in_rng) begin
                    state_q <= S_EXEC;
                  end else begin
                    done_o   <= 1'b1;
                    status_o <= RS_RANGE;
                  end
                end
                default: done_o <= 1'b1;
              endcase
            end
          end
        end
        S_EXEC: begin
          done_o  <= 1'b1;
          state_q <= S_IDLE;
          priority case (cmd_q)
            CMD_LOCK: begin
              if (lk_ok && (len_q < LOG_FULL)) begin
                if (end_q) begin
                  len_q <= '0;
                  bf_q  <= 1'b0;
                end else begin
                  len_q <= len_q + LLW'(1);
                end
              end else begin
                bf_q <= !end_q;
                if (len_q != '0) begin
                  done_o  <= 1'b0;
                  fail_q  <= lk_ok ? RS_OVERFLOW : RS_BUSY;
                  k_q     <= '0;
                  state_q <= S_RB_LRD;
                end else begin
                  status_o <= lk_ok ? RS_OVERFLOW : RS_BUSY;
                end
              end
            end
            CMD_UNLOCK: begin
              if (mem_rdata.state != ST_LOCKED) begin
                status_o <= RS_NOTLOCKED;
                bf_q     <= !end_q;
              end else if (end_q) begin
                bf_q <= 1'b0;
              end
            end
            CMD_PREEMPT: begin
              if (end_q) bf_q <= 1'b0;
            end
            CMD_QUERY: begin
              chunk_state_out_o <= mem_rdata.state;
              pin_count_out_o   <= mem_rdata.pin;
              touch_time_out_o  <= mem_rdata.touch;
              if (mem_rdata.state == ST_EVICTED) status_o <= RS_NOTRES;
            end
            default: ;
          endcase
        end
        S_EV_RD: begin
          ptr_q   <= ev_i_q[AW-1:0] - AW'(1);
          ev_i_q  <= ev_i_q - EW'(1);
          state_q <= S_EV_WR;
        end
        S_EV_WR: begin
          freed_q <= freed_n;
          if ((ev_i_q == '0) || (freed_n == want_q)) begin
            done_o        <= 1'b1;
            freed_count_o <= freed_n;
            state_q       <= S_IDLE;
          end else begin
            state_q <= S_EV_RD;
          end
        end
        S_RG_RD: state_q <= S_RG_WR;
        S_RG_WR: begin
          if (ptr_q == hi_q) begin
            done_o  <= 1'b1;
            state_q <= S_IDLE;
          end else begin
            ptr_q   <= ptr_q + AW'(1);
            state_q <= S_RG_RD;
          end
        end
        // Rollback: read log entry, read chunk, restore its state
        S_RB_LRD: state_q <= S_RB_CRD;
        S_RB_CRD: begin
          rb_ent_q <= log_rdata;
          state_q  <= S_RB_CWR;
        end
        S_RB_CWR: begin
          k_q <= k_q + LLW'(1);
          if ((k_q + LLW'(1)) == len_q) begin
            len_q    <= '0;
            done_o   <= 1'b1;
            status_o <= fail_q;
            state_q  <= S_IDLE;
          end else begin
            state_q <= S_RB_LRD;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Lock log never grows past its depth
  assert property (@(posedge clk_i) disable iff (!rst_ni) len_q <= LOG_FULL)
    else $error("lock log length beyond depth");

  // A result always leaves the sequencer idle
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> !busy)
    else $error("result strobe while busy");

  // Only evict reports freed chunks, and it never exceeds the request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (freed_count_o != '0)) |-> ((cmd_q == CMD_EVICT) && (freed_count_o <= want_q)))
    else $error("freed count outside evict");

  // Rollback starts only with entries in the log
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RB_LRD) |-> (len_q != '0))
    else $error("rollback with empty log");

endmodule
